### rtl/scrq_pkg.sv
// Shared types and constants for the sorted column range query block.
// Used by the top level and the port checker.
package scrq_pkg;

   localparam int MAX_COLUMNS  = 64;
   localparam int MAX_ROWS     = 1024;
   localparam int VALUE_BITS   = 32;

   localparam int COL_BITS     = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS     = $clog2(MAX_ROWS);
   localparam int ROW_CNT_BITS = ROW_BITS + 1;
   localparam int CFG_BITS     = 7;
   localparam int REQ_BITS     = 2;

   // request codes
   localparam logic [REQ_BITS-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_QUERY = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

   localparam logic [ROW_BITS-1:0] MIN_RESET = '1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // one column entry: value of the previous row and start of the current run
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [ROW_BITS-1:0]   start;
   } col_entry_type;

   localparam int COL_ENTRY_BITS = $bits(col_entry_type);

endpackage

### rtl/scrq_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Standalone; the read data is registered from the address when rd_en is set.
module scrq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sorted_column_range_query.sv
// Sorted column range query: streams table elements, answers row range queries.
// Depends on scrq_pkg and two scrq_ram instances (column state, row results).
//
// Usage:
//   Input channel (req_valid/req_ready) carries one request: req_type selects
//   load element, range query or clear. Loads arrive in row-major order and
//   go to the column picked by the internal column counter; csr_num_columns
//   (csr_wr_en/csr_wr_data) sets the row width; the user must write it only
//   while idle, not enforced by the block. Result channel (rsp_valid/rsp_ready)
//   carries one answer per query: rsp_is_sorted and rsp_status (set when
//   last_row is not yet loaded). Loads and clears produce no answer.
// Sequence:
//   A load or query is accepted in idle, which issues the synchronous read of
//   the column or row RAM, then goes to the update state to update and write
//   back. A clear or unknown code is handled in idle. No new request is taken
//   while a load or query is in its update state. rsp_valid is registered and
//   rises as a query leaves its update state.
// Reset: counters clear, the running minimum goes to all ones and the column
//   count goes to 1; RAM contents stay as they are and need no clearing pass.
// Stall: a held answer sits in the output register; new loads and clears are
//   still taken, and a further query waits in its update cycle until the
//   output register frees up.
module sorted_column_range_query (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [scrq_pkg::REQ_BITS-1:0]       req_type,
   input  logic [scrq_pkg::VALUE_BITS-1:0]     req_element_value,
   input  logic [scrq_pkg::ROW_BITS-1:0]       req_first_row,
   input  logic [scrq_pkg::ROW_BITS-1:0]       req_last_row,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_sorted,
   output logic                                rsp_status,
   input  logic                                csr_wr_en,
   input  logic [scrq_pkg::CFG_BITS-1:0]       csr_wr_data
);

   scrq_pkg::state_type state_ff, state_in;

   logic [scrq_pkg::CFG_BITS-1:0]     num_cols_ff;
   logic [scrq_pkg::COL_BITS-1:0]     col_index_ff, col_index_in;
   logic [scrq_pkg::ROW_CNT_BITS-1:0] row_index_ff, row_index_in;
   logic [scrq_pkg::ROW_BITS-1:0]     run_min_ff, run_min_in;

   logic [scrq_pkg::REQ_BITS-1:0]     op_ff;
   logic [scrq_pkg::VALUE_BITS-1:0]   value_ff;
   logic [scrq_pkg::ROW_BITS-1:0]     first_ff;
   logic [scrq_pkg::ROW_BITS-1:0]     last_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic is_sorted_ff, is_sorted_in;
   logic status_ff, status_in;

   logic                               req_accept;
   logic [scrq_pkg::CFG_BITS-1:0]      cols_eff;
   logic                               table_full;
   logic                               row_end;
   logic                               rsp_free;
   logic [scrq_pkg::ROW_BITS-1:0]      start;
   logic [scrq_pkg::ROW_BITS-1:0]      new_min;
   logic                               col_wr_en;
   logic                               row_wr_en;
   scrq_pkg::col_entry_type            col_rd, col_wr;
   logic [scrq_pkg::COL_ENTRY_BITS-1:0] col_rd_bits;
   logic [scrq_pkg::ROW_BITS-1:0]      row_rd;
   logic                               past_loaded;

   assign req_ready  = (state_ff == scrq_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // saturate the column count into 1..MAX_COLUMNS
   always_comb begin
      if (num_cols_ff == '0) begin
         cols_eff = scrq_pkg::CFG_BITS'(1);
      end else if (num_cols_ff > scrq_pkg::CFG_BITS'(scrq_pkg::MAX_COLUMNS)) begin
         cols_eff = scrq_pkg::CFG_BITS'(scrq_pkg::MAX_COLUMNS);
      end else begin
         cols_eff = num_cols_ff;
      end
   end

   assign table_full = (row_index_ff >= scrq_pkg::ROW_CNT_BITS'(scrq_pkg::MAX_ROWS));
   assign row_end    = ({1'b0, col_index_ff} + scrq_pkg::CFG_BITS'(1)) >= cols_eff;

   assign col_rd = scrq_pkg::col_entry_type'(col_rd_bits);

   // run continues while the value does not drop below the one above it
   always_comb begin
      if (row_index_ff == '0) begin
         start = '0;
      end else if (value_ff >= col_rd.value) begin
         start = col_rd.start;
      end else begin
         start = row_index_ff[scrq_pkg::ROW_BITS-1:0];
      end
      new_min = (start < run_min_ff) ? start : run_min_ff;
   end

   assign col_wr.value = value_ff;
   assign col_wr.start = start;

   assign past_loaded = ({1'b0, last_ff} >= row_index_ff);

   always_comb begin
      state_in     = state_ff;
      col_index_in = col_index_ff;
      row_index_in = row_index_ff;
      run_min_in   = run_min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      is_sorted_in = is_sorted_ff;
      status_in    = status_ff;
      col_wr_en    = 1'b0;
      row_wr_en    = 1'b0;
      case (state_ff)
         scrq_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  scrq_pkg::REQ_LOAD,
                  scrq_pkg::REQ_QUERY: state_in = scrq_pkg::ST_EXEC;
                  scrq_pkg::REQ_CLEAR: begin
                     col_index_in = '0;
                     row_index_in = '0;
                     run_min_in   = scrq_pkg::MIN_RESET;
                  end
                  default: ;
               endcase
            end
         end
         scrq_pkg::ST_EXEC: begin
            if (op_ff == scrq_pkg::REQ_QUERY) begin
               // hold until the output register can take the answer
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  status_in    = past_loaded;
                  is_sorted_in = !past_loaded && (row_rd <= first_ff);
                  state_in     = scrq_pkg::ST_IDLE;
               end
            end else begin
               state_in = scrq_pkg::ST_IDLE;
               if (!table_full) begin
                  col_wr_en = 1'b1;
                  if (row_end) begin
                     row_wr_en    = 1'b1;
                     run_min_in   = scrq_pkg::MIN_RESET;
                     col_index_in = '0;
                     row_index_in = row_index_ff + scrq_pkg::ROW_CNT_BITS'(1);
                  end else begin
                     run_min_in   = new_min;
                     col_index_in = col_index_ff + scrq_pkg::COL_BITS'(1);
                  end
               end
            end
         end
         default: state_in = scrq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scrq_pkg::ST_IDLE;
         col_index_ff <= '0;
         row_index_ff <= '0;
         run_min_ff   <= scrq_pkg::MIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_index_ff <= col_index_in;
         row_index_ff <= row_index_in;
         run_min_ff   <= run_min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= scrq_pkg::CFG_BITS'(1);
      end else if (csr_wr_en) begin
         num_cols_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      is_sorted_ff <= is_sorted_in;
      status_ff    <= status_in;
      if (req_accept) begin
         op_ff    <= req_type;
         value_ff <= req_element_value;
         first_ff <= req_first_row;
         last_ff  <= req_last_row;
      end
   end

   scrq_ram #(
      .DEPTH (scrq_pkg::MAX_COLUMNS),
      .WIDTH (scrq_pkg::COL_ENTRY_BITS)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_index_ff),
      .wr_data (col_wr),
      .rd_en   (req_accept),
      .rd_addr (col_index_ff),
      .rd_data (col_rd_bits)
   );

   scrq_ram #(
      .DEPTH (scrq_pkg::MAX_ROWS),
      .WIDTH (scrq_pkg::ROW_BITS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_index_ff[scrq_pkg::ROW_BITS-1:0]),
      .wr_data (new_min),
      .rd_en   (req_accept),
      .rd_addr (req_last_row),
      .rd_data (row_rd)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_sorted = is_sorted_ff;
   assign rsp_status    = status_ff;

endmodule

### rtl/scrq_checker.sv
// Port-level checker for sorted_column_range_query, attached by bind.
// Depends on scrq_pkg for the request codes.
module scrq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [scrq_pkg::REQ_BITS-1:0]       req_type,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_is_sorted,
   input logic                                rsp_status
);

   // a stalled answer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_sorted) && $stable(rsp_status))
      else $error("stalled response changed");

   // a new answer follows an accepted query request
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_type == scrq_pkg::REQ_QUERY, 2))
      else $error("response without matching query");

   // loads and queries occupy the update cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_type == scrq_pkg::REQ_LOAD || req_type == scrq_pkg::REQ_QUERY) |=> !req_ready)
      else $error("request taken during update cycle");

   // an unloaded row is never reported sorted
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_is_sorted)
      else $error("flagged response reports sorted");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_column_range_query scrq_checker u_scrq_checker (.*);
